// ===== design/ddsp_pkg.sv =====
// shared constants for the dotted date string parser
`timescale 1ns / 1ps

package ddsp_pkg;

    // default accumulator width
    localparam int VALUE_WIDTH_DEF = 16;

    // width of each result field on the output stream
    localparam int FIELD_W = 16;

    // stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int STATUS_W    = 3;
    localparam int OUT_TDATA_W = 56;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DAY_SYM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_DOT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MONTH_SYM = 3'd3;
    localparam logic [STATUS_W-1:0] ST_YEAR_SYM  = 3'd4;

    // character codes
    localparam logic [IN_TDATA_W-1:0] CH_TERM = 8'h00;
    localparam logic [IN_TDATA_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [IN_TDATA_W-1:0] CH_ZERO = 8'h30;
    localparam logic [IN_TDATA_W-1:0] CH_NINE = 8'h39;

endpackage

// ===== design/dotted_date_string_parser_core.sv =====
// top level of the dotted date string parser (dd.mm.yyyy)
`timescale 1ns / 1ps

// Takes a date string one character per transfer, ended by a zero byte, and
// gives one result transfer per string: status and day, month and year values.
// One character is taken every clock cycle unless the input is stalled; the per-character update (one
// multiply-by-ten, add and saturate unit shared by the three fields) completes
// in the cycle the character is accepted. The result of a terminator appears
// on the output in the cycle after it is accepted when the output register is
// free or being read; behind a stalled result it waits in the second entry.
// A two-entry output stage lets input keep flowing while a result waits; input
// stalls only when both entries are full. Fields read zero whenever the status
// is not ok, and each field saturates at 2^VALUE_WIDTH-1 before being cut to
// its 16 output bits.
module dotted_date_string_parser_core #(
    parameter int VALUE_WIDTH = ddsp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream; tdata: char_code[7:0]
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ddsp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // output stream; tdata: status[2:0], day_value[18:3], month_value[34:19],
    // year_value[50:35], zero[55:51]
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [ddsp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    typedef enum logic [1:0] {
        PH_DAY   = 2'd0,
        PH_MONTH = 2'd1,
        PH_YEAR  = 2'd2
    } t_phase;

    localparam int FW  = ddsp_pkg::FIELD_W;
    localparam int SW  = ddsp_pkg::STATUS_W;
    localparam int PAD = ddsp_pkg::OUT_TDATA_W - SW - 3 * FW;

    t_phase                r_phase;
    logic [SW-1:0]         r_err;
    logic [VALUE_WIDTH-1:0] r_day, r_month, r_year;

    t_phase                n_phase;
    logic [SW-1:0]         n_err;
    logic [VALUE_WIDTH-1:0] n_day, n_month, n_year;

    logic                              r_out_valid, r_skid_valid;
    logic [ddsp_pkg::OUT_TDATA_W-1:0]  r_out_data, r_skid_data;

    logic                   accept, is_term, is_digit, is_dot;
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] acc_sel, acc_push;
    logic [VALUE_WIDTH+3:0] acc_wide;
    logic [SW-1:0]          res_status;
    logic [VALUE_WIDTH+FW-1:0] day_ext, month_ext, year_ext;
    logic [ddsp_pkg::OUT_TDATA_W-1:0] res_data;

    // input handshake
    assign o_s_axis_tready = !r_skid_valid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // character class
    assign is_term  = (i_s_axis_tdata == ddsp_pkg::CH_TERM);
    assign is_dot   = (i_s_axis_tdata == ddsp_pkg::CH_DOT);
    assign is_digit = (i_s_axis_tdata >= ddsp_pkg::CH_ZERO)
                   && (i_s_axis_tdata <= ddsp_pkg::CH_NINE);
    always_comb begin
        logic [ddsp_pkg::IN_TDATA_W-1:0] diff;
        diff  = i_s_axis_tdata - ddsp_pkg::CH_ZERO;
        digit = diff[3:0];
    end

    // shared accumulate unit: acc * 10 + digit, saturating
    always_comb begin
        unique case (r_phase)
            PH_DAY:   acc_sel = r_day;
            PH_MONTH: acc_sel = r_month;
            default:  acc_sel = r_year;
        endcase
        acc_wide = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
                 + {{VALUE_WIDTH{1'b0}}, digit};
        if (acc_wide[VALUE_WIDTH+3:VALUE_WIDTH] != 4'b0) begin
            acc_push = {VALUE_WIDTH{1'b1}};
        end else begin
            acc_push = acc_wide[VALUE_WIDTH-1:0];
        end
    end

    // next parser state
    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        if (is_term) begin
            n_phase = PH_DAY;
            n_err   = ddsp_pkg::ST_OK;
            n_day   = '0;
            n_month = '0;
            n_year  = '0;
        end else if (r_err == ddsp_pkg::ST_OK) begin
            unique case (r_phase)
                PH_DAY: begin
                    if (is_digit) begin
                        n_day = acc_push;
                    end else if (is_dot) begin
                        n_phase = PH_MONTH;
                    end else begin
                        n_err = ddsp_pkg::ST_DAY_SYM;
                    end
                end
                PH_MONTH: begin
                    if (is_digit) begin
                        n_month = acc_push;
                    end else if (is_dot) begin
                        n_phase = PH_YEAR;
                    end else begin
                        n_err = ddsp_pkg::ST_MONTH_SYM;
                    end
                end
                default: begin
                    if (is_digit) begin
                        n_year = acc_push;
                    end else begin
                        n_err = ddsp_pkg::ST_YEAR_SYM;
                    end
                end
            endcase
        end
    end

    // result of a terminator
    assign day_ext   = {{FW{1'b0}}, r_day};
    assign month_ext = {{FW{1'b0}}, r_month};
    assign year_ext  = {{FW{1'b0}}, r_year};
    always_comb begin
        res_status = r_err;
        if (r_err == ddsp_pkg::ST_OK && r_phase != PH_YEAR) begin
            res_status = ddsp_pkg::ST_NO_DOT;
        end
        if (res_status == ddsp_pkg::ST_OK) begin
            res_data = {{PAD{1'b0}}, year_ext[FW-1:0], month_ext[FW-1:0],
                        day_ext[FW-1:0], res_status};
        end else begin
            res_data = {{PAD{1'b0}}, {(3 * FW){1'b0}}, res_status};
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DAY;
            r_err   <= ddsp_pkg::ST_OK;
            r_day   <= '0;
            r_month <= '0;
            r_year  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
        end
    end

    // two-entry output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid  <= r_skid_valid || (accept && is_term);
            r_skid_valid <= 1'b0;
        end else if (accept && is_term) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (accept && is_term) begin
                r_out_data <= res_data;
            end
        end else if (accept && is_term) begin
            r_skid_data <= res_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== design/ddsp_checker.sv =====
// port-level checker for the dotted date string parser, bound to the top level
`timescale 1ns / 1ps

module ddsp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [ddsp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [ddsp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] != ddsp_pkg::ST_OK
        |-> o_m_axis_tdata[50:3] == '0)
        else $error("nonzero field with error status");

    // input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    // a terminator into an empty output shows a result next cycle
    a_term_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata == ddsp_pkg::CH_TERM
        && !o_m_axis_tvalid |=> o_m_axis_tvalid)
        else $error("terminator gave no result");

endmodule

bind dotted_date_string_parser_core ddsp_checker u_ddsp_checker (.*);

// ===== sim/ddsp_date_checker.sv =====
// checker that predicts and compares the parsed date results of the parser core
`timescale 1ns / 1ps

module ddsp_date_checker #(
    parameter int VALUE_WIDTH = ddsp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // character stream; tdata: char_code[7:0]
    input  logic                             i_char_tvalid,
    input  logic                             i_char_tready,
    input  logic [ddsp_pkg::IN_TDATA_W-1:0]  i_char_tdata,
    // date stream; tdata: status[2:0], day_value[18:3], month_value[34:19],
    // year_value[50:35], zero[55:51]
    input  logic                             i_date_tvalid,
    input  logic                             i_date_tready,
    input  logic [ddsp_pkg::OUT_TDATA_W-1:0] i_date_tdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import ddsp_pkg::*;

    typedef enum logic [1:0] {
        PH_DAY   = 2'd0,
        PH_MONTH = 2'd1,
        PH_YEAR  = 2'd2
    } field_phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  day;
        logic [FIELD_W-1:0]  month;
        logic [FIELD_W-1:0]  year;
    } date_result_t;

    localparam logic [VALUE_WIDTH-1:0] ACC_MAX = '1;
    localparam int PAD_LSB = STATUS_W + 3 * FIELD_W;

    // predicted parser state
    field_phase_t           field_phase = PH_DAY;
    logic [STATUS_W-1:0]    first_err   = ST_OK;
    logic [VALUE_WIDTH-1:0] day_acc     = '0;
    logic [VALUE_WIDTH-1:0] month_acc   = '0;
    logic [VALUE_WIDTH-1:0] year_acc    = '0;

    date_result_t expected_dates[$];
    int           fail_count = 0;

    // decimal shift-in with saturation at the accumulator maximum
    function automatic logic [VALUE_WIDTH-1:0] push_digit(
        input logic [VALUE_WIDTH-1:0] acc,
        input logic [3:0]             digit
    );
        logic [VALUE_WIDTH+3:0] wide;
        wide = (VALUE_WIDTH + 4)'(acc) * 10 + digit;
        return (wide > ACC_MAX) ? ACC_MAX : wide[VALUE_WIDTH-1:0];
    endfunction

    task automatic clear_state();
        field_phase = PH_DAY;
        first_err   = ST_OK;
        day_acc     = '0;
        month_acc   = '0;
        year_acc    = '0;
    endtask

    // advance the prediction by one character, queue a result on the terminator
    task automatic parse_char(input logic [IN_TDATA_W-1:0] c);
        logic         is_digit;
        logic [3:0]   digit;
        date_result_t res;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        digit    = 4'(c - CH_ZERO);
        if (c == CH_TERM) begin
            res.status = first_err;
            // terminator before the year field is reached
            if (first_err == ST_OK && field_phase != PH_YEAR)
                res.status = ST_NO_DOT;
            if (res.status == ST_OK) begin
                res.day   = FIELD_W'(day_acc);
                res.month = FIELD_W'(month_acc);
                res.year  = FIELD_W'(year_acc);
            end else begin
                res.day   = '0;
                res.month = '0;
                res.year  = '0;
            end
            expected_dates.push_back(res);
            clear_state();
        end else if (first_err == ST_OK) begin
            // characters after the first error are ignored
            case (field_phase)
                PH_DAY: begin
                    if (is_digit)
                        day_acc = push_digit(day_acc, digit);
                    else if (c == CH_DOT)
                        field_phase = PH_MONTH;
                    else
                        first_err = ST_DAY_SYM;
                end
                PH_MONTH: begin
                    if (is_digit)
                        month_acc = push_digit(month_acc, digit);
                    else if (c == CH_DOT)
                        field_phase = PH_YEAR;
                    else
                        first_err = ST_MONTH_SYM;
                end
                default: begin
                    // a dot in the year field is a symbol error too
                    if (is_digit)
                        year_acc = push_digit(year_acc, digit);
                    else
                        first_err = ST_YEAR_SYM;
                end
            endcase
        end
    endtask

    task automatic check_field(input string field_name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
            fail_count++;
        end
    endtask

    // compare results first, then fold in the character of the same edge
    always @(posedge i_clk) begin : date_check
        date_result_t want;
        if (!i_rst_n) begin
            clear_state();
            expected_dates.delete();
        end else begin
            if (i_date_tvalid && i_date_tready) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t: unexpected date result, expected none, actual tdata %h",
                             $time, i_date_tdata);
                    fail_count++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("status", want.status, i_date_tdata[STATUS_W-1:0]);
                    check_field("day", want.day, i_date_tdata[STATUS_W +: FIELD_W]);
                    check_field("month", want.month,
                                i_date_tdata[STATUS_W + FIELD_W +: FIELD_W]);
                    check_field("year", want.year,
                                i_date_tdata[STATUS_W + 2 * FIELD_W +: FIELD_W]);
                    check_field("padding", 0, i_date_tdata[OUT_TDATA_W-1:PAD_LSB]);
                end
            end
            if (i_char_tvalid && i_char_tready)
                parse_char(i_char_tdata);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_dates.size();
    end

endmodule

// ===== sim/tb_dotted_date_string_parser_core.sv =====
// testbench top for the dotted date string parser core: stimulus and verdict
`timescale 1ns / 1ps

module tb_dotted_date_string_parser_core;
    import ddsp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_CHARS = 400;
    localparam int STALL_CYCLES = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 10;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   char_tvalid = 1'b0;
    logic                   char_tready;
    logic [IN_TDATA_W-1:0]  char_tdata  = '0;
    logic                   date_tvalid;
    logic                   date_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] date_tdata;

    int fail_count;
    int pending_dates;
    int chars_sent    = 0;
    int src_burst     = 0;
    bit hold_request  = 1'b0;

    dotted_date_string_parser_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (char_tvalid),
        .o_s_axis_tready (char_tready),
        .i_s_axis_tdata  (char_tdata),
        .o_m_axis_tvalid (date_tvalid),
        .i_m_axis_tready (date_tready),
        .o_m_axis_tdata  (date_tdata)
    );

    ddsp_date_checker u_date_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_char_tvalid (char_tvalid),
        .i_char_tready (char_tready),
        .i_char_tdata  (char_tdata),
        .i_date_tvalid (date_tvalid),
        .i_date_tready (date_tready),
        .i_date_tdata  (date_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_dates)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_digit();
        return CH_ZERO + IN_TDATA_W'($urandom_range(0, 9));
    endfunction

    // digit count of a field, sometimes long enough to saturate
    function automatic int field_len(input int typical);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 7);
        else
            return $urandom_range(0, typical);
    endfunction

    // one character transfer, with an optional idle gap before it
    task automatic send_char(input logic [IN_TDATA_W-1:0] c);
        int gap;
        if (src_burst > 0) begin
            gap = 0;
            src_burst--;
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            char_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_tvalid <= 1'b1;
        char_tdata  <= c;
        @(posedge clk);
        while (!char_tready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // one random string followed by its terminator
    task automatic send_random_date();
        logic [IN_TDATA_W-1:0] date_chars[$];
        int kind;
        int n;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            // well-formed dd.mm.yyyy with random content, sometimes damaged
            n = field_len(2);
            repeat (n) date_chars.push_back(random_digit());
            date_chars.push_back(CH_DOT);
            n = field_len(2);
            repeat (n) date_chars.push_back(random_digit());
            date_chars.push_back(CH_DOT);
            n = field_len(4);
            repeat (n) date_chars.push_back(random_digit());
            if ($urandom_range(0, 9) < 2)
                date_chars[$urandom_range(0, date_chars.size() - 1)] =
                    IN_TDATA_W'($urandom_range(1, 255));
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(0, date_chars.size() - 1);
                while (date_chars.size() > cut)
                    date_chars.delete(date_chars.size() - 1);
            end
        end else if (kind < 90) begin
            // loose mix of digits, dots and other characters
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 2))
                    0:       date_chars.push_back(random_digit());
                    1:       date_chars.push_back(CH_DOT);
                    default: date_chars.push_back(IN_TDATA_W'($urandom_range(1, 255)));
                endcase
            end
        end else begin
            // raw bytes, possibly with an early terminator
            n = $urandom_range(1, 6);
            repeat (n) date_chars.push_back(IN_TDATA_W'($urandom_range(0, 255)));
        end
        foreach (date_chars[i])
            send_char(date_chars[i]);
        send_char(CH_TERM);
    endtask

    // result side: random backpressure plus one long hold on request
    initial begin : date_sink
        int gap;
        forever begin
            if (hold_request) begin
                date_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = ($urandom_range(0, 7) == 0) ? 0 : pick_gap();
            if (gap > 0) begin
                date_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            date_tready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 8))
                @(posedge clk);
        end
    end

    // ends the run when no transfer happens for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((char_tvalid && char_tready) || (date_tvalid && date_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and verdict
    initial begin : char_source
        int random_start;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string
        send_char(CH_TERM);
        // smallest and largest digits, year saturates
        send_text("9.0.99999");
        send_char(CH_TERM);
        // empty month and year fields
        send_text("1..");
        send_char(CH_TERM);
        // bad day symbol just above the digits
        send_text(":");
        send_char(CH_TERM);
        // bad month symbol with every bit set
        send_char(CH_DOT);
        send_char(8'hFF);
        send_char(CH_TERM);
        // bad year symbol, then a dot that must be ignored
        send_text("..");
        send_char(8'h80);
        send_char(CH_DOT);
        send_char(CH_TERM);
        // terminator in the day field and in the month field
        send_text("5");
        send_char(CH_TERM);
        send_text(".5");
        send_char(CH_TERM);

        // random strings, with one long hold on the result side early on
        random_start = chars_sent;
        hold_request = 1'b1;
        while (chars_sent - random_start < RANDOM_CHARS) begin
            if ($urandom_range(0, 5) == 0)
                src_burst = 40;
            send_random_date();
        end
        char_tvalid <= 1'b0;

        // let the last result drain
        @(posedge clk);
        while (pending_dates != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_dates == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
